// ----- sv/sic_pkg.sv -----
package sic_pkg;

  // Field and datapath widths.
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int TolBits   = 20;
  localparam int PointBits = 32;
  localparam int NumCoords = 8;
  localparam int FlagBits  = 5;

  localparam int InDataBits  = ((NumCoords * CoordBits + 7) / 8) * 8;
  localparam int OutDataBits = ((2 * PointBits + 7) / 8) * 8;

  // Coordinate differences, their products and the Cramer determinants.
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int DetBits  = ProdBits + 1;
  localparam int MagBits  = ProdBits;

  // Scaled numerator |delta| * |tn| * 2^(FracBits+1) and its quotient by |det|.
  // Any quotient at or above 2^QuotBits already drives the point past the
  // 32-bit range, so the divider only resolves QuotBits quotient bits.
  localparam int SplitBits = MagBits - MagBits / 2;
  localparam int NumBits   = DiffBits + MagBits;
  localparam int NBits     = NumBits + FracBits + 1;
  localparam int QuotBits  = PointBits + 2;
  localparam int HeadBits  = NBits - QuotBits;
  localparam int SumBits   = QuotBits + 2;

  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  // Output flag positions inside out_tuser.
  localparam int FlagParallel     = 0;
  localparam int FlagIntersecting = 1;
  localparam int FlagOutsideA     = 2;
  localparam int FlagOutsideB     = 3;
  localparam int FlagSaturated    = 4;

  // One classified segment pair, waiting for the point computation.
  typedef struct packed {
    logic                        parallel;
    logic                        intersecting;
    logic                        outside_a;
    logic                        outside_b;
    logic                        neg_x;
    logic                        neg_y;
    logic [DiffBits-1:0]         dx_mag;
    logic [DiffBits-1:0]         dy_mag;
    logic [MagBits-1:0]          tn_mag;
    logic [MagBits-1:0]          det_mag;
    logic signed [CoordBits-1:0] base_x;
    logic signed [CoordBits-1:0] base_y;
  } sic_job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } sic_qstat_t;

  // Divider lane state between two restoring steps.
  typedef struct packed {
    logic [MagBits-1:0]  rem;
    logic [QuotBits-1:0] low;
    logic [QuotBits-1:0] quo;
    logic                ovf;
  } sic_div_t;

  // Magnitude of a determinant-sized signed value.
  function automatic logic [MagBits-1:0] mag_det(logic signed [DetBits-1:0] v);
    logic signed [DetBits-1:0] n;
    n = -v;
    return v[DetBits-1] ? MagBits'(n) : MagBits'(v);
  endfunction

  // Magnitude of a coordinate difference.
  function automatic logic [DiffBits-1:0] mag_diff(logic signed [DiffBits-1:0] v);
    logic signed [DiffBits-1:0] n;
    n = -v;
    return v[DiffBits-1] ? DiffBits'(n) : DiffBits'(v);
  endfunction

endpackage

// ----- sv/sic_front.sv -----
module sic_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sic_pkg::InDataBits-1:0]     in_tdata,
  input  logic [sic_pkg::TolBits-1:0]        tol,
  input  sic_pkg::sic_qstat_t                qstat,
  output logic                               push,
  output sic_pkg::sic_job_t                  push_job
);

  localparam int CB = sic_pkg::CoordBits;
  localparam int DB = sic_pkg::DiffBits;
  localparam int PB = sic_pkg::ProdBits;
  localparam int TB = sic_pkg::DetBits;

  logic fen;

  // Stage 1: coordinate differences.
  logic                 v1_r;
  logic signed [DB-1:0] ma_r, mb_r, mc_r, md_r, rx_r, ry_r;
  logic signed [CB-1:0] ax0_r, ay0_r;
  logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  // Stage 2: the six cross products.
  logic                 v2_r;
  logic signed [PB-1:0] p_ad_r, p_bc_r, p_dx_r, p_by_r, p_ay_r, p_cx_r;
  logic signed [DB-1:0] ma2_r, mc2_r;
  logic signed [CB-1:0] ax02_r, ay02_r;

  // Stage 3: determinant and numerators.
  logic                 v3_r;
  logic signed [TB-1:0] det_r, tn_r, sn_r;
  logic signed [DB-1:0] ma3_r, mc3_r;
  logic signed [CB-1:0] ax03_r, ay03_r;

  // Classification from stage 3.
  logic [sic_pkg::MagBits-1:0] dp;
  logic signed [TB:0]          tp, sp, dps;
  logic                        out_a, out_b, det_neg, tn_neg;

  assign fen       = !(v3_r && qstat.full);
  assign in_tready = fen;

  assign ax0 = in_tdata[0*CB +: CB];
  assign ay0 = in_tdata[1*CB +: CB];
  assign ax1 = in_tdata[2*CB +: CB];
  assign ay1 = in_tdata[3*CB +: CB];
  assign bx0 = in_tdata[4*CB +: CB];
  assign by0 = in_tdata[5*CB +: CB];
  assign bx1 = in_tdata[6*CB +: CB];
  assign by1 = in_tdata[7*CB +: CB];

  // Valid bits advance with the front enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (fen) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers of the three front stages.
  always_ff @(posedge clk) begin
    if (fen) begin
      ma_r   <= DB'(ax1) - DB'(ax0);
      mb_r   <= DB'(bx0) - DB'(bx1);
      mc_r   <= DB'(ay1) - DB'(ay0);
      md_r   <= DB'(by0) - DB'(by1);
      rx_r   <= DB'(bx0) - DB'(ax0);
      ry_r   <= DB'(by0) - DB'(ay0);
      ax0_r  <= ax0;
      ay0_r  <= ay0;

      p_ad_r <= ma_r * md_r;
      p_bc_r <= mb_r * mc_r;
      p_dx_r <= md_r * rx_r;
      p_by_r <= mb_r * ry_r;
      p_ay_r <= ma_r * ry_r;
      p_cx_r <= mc_r * rx_r;
      ma2_r  <= ma_r;
      mc2_r  <= mc_r;
      ax02_r <= ax0_r;
      ay02_r <= ay0_r;

      det_r  <= TB'(p_ad_r) - TB'(p_bc_r);
      tn_r   <= TB'(p_dx_r) - TB'(p_by_r);
      sn_r   <= TB'(p_ay_r) - TB'(p_cx_r);
      ma3_r  <= ma2_r;
      mc3_r  <= mc2_r;
      ax03_r <= ax02_r;
      ay03_r <= ay02_r;
    end
  end

  // Range tests compare the numerators with |det| after flipping by its sign.
  always_comb begin
    det_neg = det_r[TB-1];
    tn_neg  = tn_r[TB-1];
    dp      = sic_pkg::mag_det(det_r);
    dps     = $signed({2'b00, dp});
    tp      = det_neg ? -(TB+1)'(tn_r) : (TB+1)'(tn_r);
    sp      = det_neg ? -(TB+1)'(sn_r) : (TB+1)'(sn_r);
    out_a   = tp[TB] || (tp > dps);
    out_b   = sp[TB] || (sp > dps);

    push_job.parallel     = (dp <= sic_pkg::MagBits'(tol));
    push_job.intersecting = !out_a;
    push_job.outside_a    = out_a;
    push_job.outside_b    = out_b;
    push_job.neg_x        = ma3_r[DB-1] ^ tn_neg ^ det_neg;
    push_job.neg_y        = mc3_r[DB-1] ^ tn_neg ^ det_neg;
    push_job.dx_mag       = sic_pkg::mag_diff(ma3_r);
    push_job.dy_mag       = sic_pkg::mag_diff(mc3_r);
    push_job.tn_mag       = sic_pkg::mag_det(tn_r);
    push_job.det_mag      = dp;
    push_job.base_x       = ax03_r;
    push_job.base_y       = ay03_r;
  end

  assign push = v3_r && !qstat.full;

endmodule

// ----- sv/sic_queue.sv -----
module sic_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sic_pkg::sic_job_t   push_job,
  input  logic                pop,
  output sic_pkg::sic_job_t   pop_job,
  output sic_pkg::sic_qstat_t qstat
);

  localparam int PW = sic_pkg::QPtrBits;

  sic_pkg::sic_job_t mem_r [sic_pkg::QueueDepth];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PW:0]       count_r;
  logic              do_push, do_pop;

  assign qstat.full  = (count_r == (PW+1)'(sic_pkg::QueueDepth));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_job     = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- sv/sic_back.sv -----
module sic_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sic_pkg::sic_qstat_t                 qstat,
  input  sic_pkg::sic_job_t                   job,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sic_pkg::OutDataBits-1:0]     out_tdata,
  output logic [sic_pkg::FlagBits-1:0]        out_tuser
);

  localparam int QB  = sic_pkg::QuotBits;
  localparam int MB  = sic_pkg::MagBits;
  localparam int DB  = sic_pkg::DiffBits;
  localparam int SB  = sic_pkg::SplitBits;
  localparam int NB  = sic_pkg::NBits;
  localparam int SUB = sic_pkg::SumBits;
  localparam int PB  = sic_pkg::PointBits;

  logic ben;

  // Multiply stage: two partial products per lane.
  logic                   vm_r;
  sic_pkg::sic_job_t      jm_r;
  logic [DB+SB-1:0]       pp_lo_r [2];
  logic [DB+MB-SB-1:0]    pp_hi_r [2];

  // Divider stages: index 0 is loaded from the multiply stage.
  logic                   vd_r   [QB+1];
  sic_pkg::sic_job_t      jd_r   [QB+1];
  sic_pkg::sic_div_t      dv_r   [QB+1][2];

  // Output register.
  logic                   out_valid_r;
  logic [PB-1:0]          px_r, py_r;
  logic [sic_pkg::FlagBits-1:0] flags_r;

  assign ben        = !out_valid_r || out_tready;
  assign pop        = ben && !qstat.empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = sic_pkg::OutDataBits'({py_r, px_r});
  assign out_tuser  = flags_r;

  // Multiply stage: |delta| times the two halves of |tn|.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (ben) begin
      vm_r <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      jm_r       <= job;
      pp_lo_r[0] <= job.dx_mag * job.tn_mag[SB-1:0];
      pp_hi_r[0] <= job.dx_mag * job.tn_mag[MB-1:SB];
      pp_lo_r[1] <= job.dy_mag * job.tn_mag[SB-1:0];
      pp_hi_r[1] <= job.dy_mag * job.tn_mag[MB-1:SB];
    end
  end

  // Numerator assembly and overflow test against the top quotient range.
  sic_pkg::sic_div_t div0 [2];
  always_comb begin
    logic [sic_pkg::NumBits-1:0]  prod;
    logic [NB-1:0]                num;
    logic [sic_pkg::HeadBits-1:0] head;
    for (int l = 0; l < 2; l++) begin
      prod = (sic_pkg::NumBits'(pp_hi_r[l]) << SB) + sic_pkg::NumBits'(pp_lo_r[l]);
      num  = {prod, (sic_pkg::FracBits+1)'(0)};
      head = num[NB-1:QB];
      div0[l].ovf = (sic_pkg::HeadBits+MB)'(head) >= (sic_pkg::HeadBits+MB)'(jm_r.det_mag);
      div0[l].rem = div0[l].ovf ? '0 : MB'(head);
      div0[l].low = num[QB-1:0];
      div0[l].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (ben) begin
      vd_r[0] <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      jd_r[0]    <= jm_r;
      dv_r[0][0] <= div0[0];
      dv_r[0][1] <= div0[1];
    end
  end

  // One restoring quotient bit per stage and lane.
  for (genvar i = 1; i <= QB; i++) begin : g_div
    sic_pkg::sic_div_t step [2];

    always_comb begin
      logic [MB:0] shifted;
      logic        ge;
      for (int l = 0; l < 2; l++) begin
        shifted      = {dv_r[i-1][l].rem, dv_r[i-1][l].low[QB-1]};
        ge           = shifted >= (MB+1)'(jd_r[i-1].det_mag);
        step[l].rem  = ge ? MB'(shifted - (MB+1)'(jd_r[i-1].det_mag)) : MB'(shifted);
        step[l].low  = dv_r[i-1][l].low << 1;
        step[l].quo  = {dv_r[i-1][l].quo[QB-2:0], ge};
        step[l].ovf  = dv_r[i-1][l].ovf;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[i] <= 1'b0;
      end else if (ben) begin
        vd_r[i] <= vd_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        jd_r[i]    <= jd_r[i-1];
        dv_r[i][0] <= step[0];
        dv_r[i][1] <= step[1];
      end
    end
  end

  // Rounding, offset from A's start point, and clamping to 32 bits.
  logic [PB-1:0] pt [2];
  logic          sat [2];
  always_comb begin
    logic [QB-1:0]                 m;
    logic [QB:0]                   q1;
    logic signed [SUB-1:0]         base_s, off, v;
    logic                          neg;
    logic signed [sic_pkg::CoordBits-1:0] base;
    for (int l = 0; l < 2; l++) begin
      base   = (l == 0) ? jd_r[QB].base_x : jd_r[QB].base_y;
      neg    = (l == 0) ? jd_r[QB].neg_x : jd_r[QB].neg_y;
      q1     = {1'b0, dv_r[QB][l].quo} + 1'b1;
      m      = dv_r[QB][l].ovf ? (QB'(1) << (QB-1)) : QB'(q1 >> 1);
      base_s = SUB'(base) <<< sic_pkg::FracBits;
      off    = neg ? -$signed(SUB'(m)) : $signed(SUB'(m));
      v      = base_s + off;
      sat[l] = (v[SUB-1:PB-1] != '0) && (v[SUB-1:PB-1] != '1);
      if (sat[l]) begin
        pt[l] = v[SUB-1] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
      end else begin
        pt[l] = v[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ben) begin
      out_valid_r <= vd_r[QB];
    end
  end

  // A parallel pair reports only its flag.
  always_ff @(posedge clk) begin
    if (ben) begin
      if (jd_r[QB].parallel) begin
        px_r    <= '0;
        py_r    <= '0;
        flags_r <= sic_pkg::FlagBits'(1) << sic_pkg::FlagParallel;
      end else begin
        px_r    <= pt[0];
        py_r    <= pt[1];
        flags_r[sic_pkg::FlagParallel]     <= 1'b0;
        flags_r[sic_pkg::FlagIntersecting] <= jd_r[QB].intersecting;
        flags_r[sic_pkg::FlagOutsideA]     <= jd_r[QB].outside_a;
        flags_r[sic_pkg::FlagOutsideB]     <= jd_r[QB].outside_b;
        flags_r[sic_pkg::FlagSaturated]    <= sat[0] || sat[1];
      end
    end
  end

endmodule

// ----- sv/segment_intersection_classify.sv -----
// Channel   Direction  Handshake           Payload
// in_       input      in_tvalid/tready    tdata: eight 16-bit signed endpoint coordinates
// out_      output     out_tvalid/tready   tdata: point_x, point_y; tuser: five flags
// cfg_      input      cfg_wr_en           cfg_wr_data: parallel_tolerance
//
// One segment pair is accepted per cycle while the front stages are not stalled;
// each point is formed by the 34-stage restoring divider.
// Reset (rst_n low at a clock edge) empties the pipeline and queue and clears
// the tolerance to zero.
// The front stages stall only when the four-entry queue is full; the back
// pipeline stalls as a whole while a finished result waits on out_tready.
module segment_intersection_classify (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [sic_pkg::InDataBits-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x, point_y
  output logic [sic_pkg::OutDataBits-1:0]    out_tdata,
  // parallel, intersecting, outside_a, outside_b, saturated
  output logic [sic_pkg::FlagBits-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [sic_pkg::TolBits-1:0]        cfg_wr_data
);

  logic [sic_pkg::TolBits-1:0] tol_r;
  sic_pkg::sic_qstat_t         qstat;
  sic_pkg::sic_job_t           push_job, pop_job;
  logic                        push, pop;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  sic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .tol       (tol_r),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job)
  );

  sic_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  sic_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .job        (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sv/sic_checker.sv -----
module sic_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sic_pkg::OutDataBits-1:0]    out_tdata,
  input logic [sic_pkg::FlagBits-1:0]       out_tuser
);

  // No result appears in the first cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A parallel pair carries no point and no other flag.
  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[sic_pkg::FlagParallel] |->
      out_tdata == '0 && out_tuser[sic_pkg::FlagBits-1:1] == '0)
    else $error("parallel result with nonzero fields");

  // Otherwise the point lies either within A or outside it, never both.
  a_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[sic_pkg::FlagParallel] |->
      out_tuser[sic_pkg::FlagIntersecting] != out_tuser[sic_pkg::FlagOutsideA])
    else $error("intersecting and outside_a disagree");

endmodule

bind segment_intersection_classify sic_checker u_sic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
